// ===== hw/rtl/stl_pkg.sv =====
// Shared types, constants and a helper function of the lattice snapping block.
`default_nettype none
package stl_pkg;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;

   // Register index, taken from address bit 3 (registers are 8 bytes apart).
   localparam logic REG_SCALE = 1'b0;
   localparam logic [63:0] SCALE_RESET = 64'h3FF0_0000_0000_0000;

   typedef logic [63:0]        coord_type;
   typedef logic signed [63:0] lattice_type;
   typedef logic signed [12:0] exp_type;

   // Result class codes carried down the pipeline.
   typedef logic [1:0] snap_class_type;
   localparam snap_class_type CLS_NUM    = 2'd0;
   localparam snap_class_type CLS_ZERO   = 2'd1;
   localparam snap_class_type CLS_SAT_HI = 2'd2;
   localparam snap_class_type CLS_SAT_LO = 2'd3;

   localparam exp_type EXP_BIAS = 13'sd1023;
   // 9.2e18 equals this mantissa at unbiased exponent 62.
   localparam logic [52:0] SAT_MANT = 53'd8984375000000000;

   localparam lattice_type LATTICE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam lattice_type LATTICE_MIN = 64'sh8000_0000_0000_0000;

   typedef struct packed {
      logic [52:0] mant;
      exp_type     exp;
   } norm_type;

   // Puts the hidden bit at bit 52, also for subnormal operands.
   function automatic norm_type norm_operand(input logic [63:0] bits);
      logic [10:0] e;
      logic [52:0] m;
      logic [5:0]  lz;
      norm_type    r;
      e  = bits[62:52];
      m  = {(e != 11'd0), bits[51:0]};
      lz = 6'd0;
      for (int i = 0; i < 53; i++) begin
         if (m[i]) begin
            lz = 6'(52 - i);
         end
      end
      r.mant = m << lz;
      if (e == 11'd0) begin
         r.exp = (13'sd1 - EXP_BIAS) - $signed({7'b0, lz});
      end else begin
         r.exp = $signed({2'b0, e}) - EXP_BIAS;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/stl_req_if.sv =====
// Input channel carrying one double coordinate per transfer.
`default_nettype none
interface stl_req_if;
   import stl_pkg::*;
   logic      valid;
   logic      ready;
   coord_type coord_bits;
   modport source (output valid, output coord_bits, input ready);
   modport sink (input valid, input coord_bits, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/stl_rsp_if.sv =====
// Result channel carrying one lattice integer per transfer.
`default_nettype none
interface stl_rsp_if;
   import stl_pkg::*;
   logic        valid;
   logic        ready;
   lattice_type lattice_value;
   modport source (output valid, output lattice_value, input ready);
   modport sink (input valid, input lattice_value, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/stl_mant_mul.sv =====
// 53x53 mantissa multiplier built from four registered partial products.
`default_nettype none
module stl_mant_mul (
   input  wire logic          clock,
   input  wire logic          load,
   input  wire logic [52:0]   a,
   input  wire logic [52:0]   b,
   output logic      [105:0]  product
);
   import stl_pkg::*;

   logic [51:0] hh_ff;
   logic [52:0] hl_ff;
   logic [52:0] lh_ff;
   logic [53:0] ll_ff;
   logic [53:0] mid;

   always_ff @(posedge clock) begin
      if (load) begin
         hh_ff <= 52'(a[52:27]) * 52'(b[52:27]);
         hl_ff <= 53'(a[52:27]) * 53'(b[26:0]);
         lh_ff <= 53'(a[26:0]) * 53'(b[52:27]);
         ll_ff <= 54'(a[26:0]) * 54'(b[26:0]);
      end
   end

   assign mid     = {1'b0, hl_ff} + {1'b0, lh_ff};
   assign product = {hh_ff, 54'b0} + {25'b0, mid, 27'b0} + {52'b0, ll_ff};

endmodule
`default_nettype wire

// ===== hw/rtl/snap_to_integer_lattice.sv =====
// Scales a double coordinate and rounds it to a saturated signed 64-bit lattice integer.
// Throughput: one coordinate per cycle while the result side does not stall, through an
// 8-stage pipeline with per-stage valids.
// Stages: input register, operand normalize, partial products, product sum, mantissa round,
// lattice align, tie adjust and shift, sign and saturation select.
// Reset clears all stage valids and loads a scale of 1.0; payload registers are not reset.
`default_nettype none
module snap_to_integer_lattice (
   input  wire logic                          clock,
   input  wire logic                          reset,
   stl_req_if.sink                            req_chan,
   stl_rsp_if.source                          rsp_chan,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [stl_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [stl_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [stl_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                               csr_pready
);
   import stl_pkg::*;

   logic [7:0] valid_ff;
   logic [7:0] adv;

   logic [63:0] scale_ff;

   coord_type      coord_ff;

   snap_class_type cls1_ff, cls1_in;
   logic           sign1_ff, sign1_in;
   logic [52:0]    ma1_ff, mb1_ff;
   exp_type        exp1_ff, exp1_in;
   norm_type       norm_a, norm_b;

   snap_class_type cls2_ff;
   logic           sign2_ff;
   exp_type        exp2_ff;
   logic [105:0]   product;

   snap_class_type cls3_ff;
   logic           sign3_ff;
   logic [52:0]    mant3_ff, mant3_in;
   logic           guard3_ff, guard3_in;
   logic           sticky3_ff, sticky3_in;
   exp_type        k3_ff, k3_in;

   snap_class_type cls4_ff;
   logic           sign4_ff;
   logic [52:0]    m4_ff, m4_in;
   exp_type        k4_ff, k4_in;
   logic [53:0]    round_sum;

   snap_class_type cls5_ff, cls5_in;
   logic           sign5_ff;
   logic [63:0]    x5_ff, x5_in;
   logic           up5_ff, up5_in;
   logic           down5_ff, down5_in;
   logic [5:0]     sh5_ff, sh5_in;
   logic [54:0]    half_sum;
   logic [5:0]     half_pos;
   logic [3:0]     big_sh;

   snap_class_type cls6_ff;
   logic           sign6_ff;
   logic [63:0]    mag6_ff, mag6_in;
   logic [63:0]    adj;

   lattice_type    value_ff, value_in;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[3] == REG_SCALE) begin
         scale_ff <= csr_pwdata;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[3] == REG_SCALE) ? scale_ff : '0;

   // A stage loads when it is empty or its content moves on in the same cycle.
   always_comb begin
      adv[7] = !valid_ff[7] || rsp_chan.ready;
      for (int i = 6; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end

   assign req_chan.ready = adv[0];
   assign rsp_chan.valid = valid_ff[7];
   assign rsp_chan.lattice_value = value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= req_chan.valid;
         end
         for (int i = 1; i < 8; i++) begin
            if (adv[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         coord_ff <= req_chan.coord_bits;
      end
   end

   // Classify special operands and normalize both mantissas.
   always_comb begin
      logic c_all, c_frac, c_zero, s_all, s_frac, s_zero;
      c_all  = &coord_ff[62:52];
      c_frac = |coord_ff[51:0];
      c_zero = (coord_ff[62:0] == 63'd0);
      s_all  = &scale_ff[62:52];
      s_frac = |scale_ff[51:0];
      s_zero = (scale_ff[62:0] == 63'd0);
      sign1_in = coord_ff[63] ^ scale_ff[63];
      priority if (c_all && !c_frac) begin
         cls1_in = coord_ff[63] ? CLS_SAT_LO : CLS_SAT_HI;
      end else if (c_all) begin
         cls1_in = CLS_ZERO;
      end else if (s_zero) begin
         cls1_in = CLS_ZERO;
      end else if (s_all && s_frac) begin
         cls1_in = CLS_ZERO;
      end else if (s_all) begin
         // An infinite scale times zero is NaN, otherwise it saturates by sign.
         cls1_in = c_zero ? CLS_ZERO : (sign1_in ? CLS_SAT_LO : CLS_SAT_HI);
      end else if (c_zero) begin
         cls1_in = CLS_ZERO;
      end else begin
         cls1_in = CLS_NUM;
      end
   end

   assign norm_a  = norm_operand(coord_ff);
   assign norm_b  = norm_operand(scale_ff);
   assign exp1_in = norm_a.exp + norm_b.exp;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         cls1_ff  <= cls1_in;
         sign1_ff <= sign1_in;
         ma1_ff   <= norm_a.mant;
         mb1_ff   <= norm_b.mant;
         exp1_ff  <= exp1_in;
      end
   end

   stl_mant_mul u_mul (
      .clock   (clock),
      .load    (adv[2]),
      .a       (ma1_ff),
      .b       (mb1_ff),
      .product (product)
   );

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         cls2_ff  <= cls1_ff;
         sign2_ff <= sign1_ff;
         exp2_ff  <= exp1_ff;
      end
   end

   // The product of two normalized mantissas lies in [2^104, 2^106).
   always_comb begin
      if (product[105]) begin
         mant3_in   = product[105:53];
         guard3_in  = product[52];
         sticky3_in = |product[51:0];
         k3_in      = exp2_ff + 13'sd1;
      end else begin
         mant3_in   = product[104:52];
         guard3_in  = product[51];
         sticky3_in = |product[50:0];
         k3_in      = exp2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         cls3_ff    <= cls2_ff;
         sign3_ff   <= sign2_ff;
         mant3_ff   <= mant3_in;
         guard3_ff  <= guard3_in;
         sticky3_ff <= sticky3_in;
         k3_ff      <= k3_in;
      end
   end

   // Round the product to nearest even.
   always_comb begin
      round_sum = {1'b0, mant3_ff} +
                  54'(guard3_ff && (sticky3_ff || mant3_ff[0]));
      if (round_sum[53]) begin
         m4_in = {1'b1, 52'b0};
         k4_in = k3_ff + 13'sd1;
      end else begin
         m4_in = round_sum[52:0];
         k4_in = k3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         cls4_ff  <= cls3_ff;
         sign4_ff <= sign3_ff;
         m4_ff    <= m4_in;
         k4_ff    <= k4_in;
      end
   end

   // Saturation checks and the half step added in units of the product's last place.
   always_comb begin
      cls5_in  = cls4_ff;
      x5_in    = '0;
      up5_in   = 1'b0;
      down5_in = 1'b0;
      sh5_in   = '0;
      half_pos = 6'(13'sd51 - k4_ff);
      big_sh   = 4'(k4_ff - 13'sd52);
      half_sum = {2'b0, m4_ff} + (55'd1 << half_pos);
      if (cls4_ff == CLS_NUM) begin
         if (k4_ff > 13'sd62 || (k4_ff == 13'sd62 && m4_ff >= SAT_MANT)) begin
            cls5_in = sign4_ff ? CLS_SAT_LO : CLS_SAT_HI;
         end else if (k4_ff < -13'sd2) begin
            cls5_in = CLS_ZERO;
         end
      end
      if (k4_ff >= 13'sd52) begin
         // The half is below half a place, or a tie that goes to the even neighbor.
         x5_in  = 64'(m4_ff) << big_sh;
         up5_in = (k4_ff == 13'sd52) && m4_ff[0];
      end else begin
         // When the sum carries into a new binade its lowest bit must be rounded off.
         x5_in    = 64'(half_sum);
         up5_in   = (|half_sum[54:53]) && half_sum[0] && half_sum[1];
         down5_in = (|half_sum[54:53]) && half_sum[0] && !half_sum[1];
         sh5_in   = 6'(13'sd52 - k4_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         cls5_ff  <= cls5_in;
         sign5_ff <= sign4_ff;
         x5_ff    <= x5_in;
         up5_ff   <= up5_in;
         down5_ff <= down5_in;
         sh5_ff   <= sh5_in;
      end
   end

   assign adj     = down5_ff ? '1 : 64'(up5_ff);
   assign mag6_in = (x5_ff + adj) >> sh5_ff;

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         cls6_ff  <= cls5_ff;
         sign6_ff <= sign5_ff;
         mag6_ff  <= mag6_in;
      end
   end

   always_comb begin
      unique case (cls6_ff)
         CLS_SAT_HI: value_in = LATTICE_MAX;
         CLS_SAT_LO: value_in = LATTICE_MIN;
         CLS_ZERO:   value_in = '0;
         default:    value_in = sign6_ff ? -$signed(mag6_ff) : $signed(mag6_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         value_ff <= value_in;
      end
   end

   // With the result register free, every stage can move and the input side is ready.
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[7] |-> req_chan.ready)
      else $error("input not ready although the result register is empty");

   a_no_lost_item: assert property (@(posedge clock) disable iff (reset)
      valid_ff[6] && adv[7] |=> valid_ff[7])
      else $error("an item vanished between the last two stages");

   a_sat_high_value: assert property (@(posedge clock) disable iff (reset)
      valid_ff[6] && adv[7] && cls6_ff == CLS_SAT_HI |=>
         rsp_chan.lattice_value == LATTICE_MAX)
      else $error("high saturation did not give the largest value");

endmodule
`default_nettype wire

// ===== tb/snap_to_integer_lattice_tb.sv =====
// Self-checking testbench for the double to lattice integer snapping block.
`timescale 1ns / 1ps
module snap_to_integer_lattice_tb;
   import stl_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 12;
   localparam logic [63:0] POS_INF = 64'h7FF0_0000_0000_0000;
   localparam logic [63:0] NEG_INF = 64'hFFF0_0000_0000_0000;
   localparam logic [63:0] ONE_BITS = 64'h3FF0_0000_0000_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   stl_req_if req_bus ();
   stl_rsp_if rsp_bus ();

   snap_to_integer_lattice u_top (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   lattice_type expected_lattice[$];
   logic [63:0] scale_shadow = SCALE_RESET;
   int error_count = 0;
   int cycle_count = 0;
   int burst_left = 0;
   int hold_left = 0;
   bit hold_request = 1'b0;
   int stall_mode = 0;
   int mode_age = 0;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.coord_bits = '0;
      rsp_bus.ready = 1'b0;
   end

   function automatic bit is_nan64(input logic [63:0] b);
      return (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
   endfunction

   // Scaled, rounded half away from zero, saturated lattice integer.
   function automatic lattice_type snap_coord(input coord_type c, input logic [63:0] s);
      real scaled;
      real t;
      longint v;
      if (c == POS_INF) return LATTICE_MAX;
      if (c == NEG_INF) return LATTICE_MIN;
      if (is_nan64(c)) return '0;
      if (s[62:0] == 63'd0) return '0;
      scaled = $bitstoreal(c) * $bitstoreal(s);
      if (is_nan64($realtobits(scaled))) return '0;
      if (scaled >= 9.2e18) return LATTICE_MAX;
      if (scaled <= -9.2e18) return LATTICE_MIN;
      if (scaled >= 0.0) t = scaled + 0.5;
      else t = scaled - 0.5;
      // The cast rounds, so step back toward zero where it overshot.
      v = longint'(t);
      if (t >= 0.0 && real'(v) > t) v = v - 1;
      if (t < 0.0 && real'(v) < t) v = v + 1;
      return lattice_type'(v);
   endfunction

   task automatic report_mismatch(input string what, input lattice_type got,
                                  input lattice_type want);
      $display("mismatch: %s got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   // Result checker: each transfer on the result side meets the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_lattice.size() == 0) begin
            report_mismatch("unexpected result", rsp_bus.lattice_value, '0);
         end else begin
            lattice_type want;
            want = expected_lattice.pop_front();
            if (rsp_bus.lattice_value !== want)
               report_mismatch("lattice_value", rsp_bus.lattice_value, want);
         end
      end
   end

   // Receiver stalls follow a pattern that changes every so often.
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = 400;
      end
      mode_age++;
      if (mode_age >= 64) begin
         mode_age = 0;
         stall_mode = $urandom_range(0, 3);
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= 1'($urandom_range(0, 1));
            2: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_bus.ready <= (mode_age % 5 != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("snap_to_integer_lattice_tb: done, errors");
         $finish;
      end
   end

   task automatic csr_write(input logic [63:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= '0;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      scale_shadow = value;
   endtask

   task automatic send_coord(input coord_type c);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 20);
      end
      burst_left--;
      req_bus.valid <= 1'b1;
      req_bus.coord_bits <= c;
      do @(posedge clock); while (!req_bus.ready);
      expected_lattice.push_back(snap_coord(c, scale_shadow));
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (expected_lattice.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic coord_type random_coord();
      case ($urandom_range(0, 9))
         0: return {$urandom, $urandom};
         1: return $realtobits(real'(longint'($urandom_range(0, 2000)) - 1000) / 2.0);
         2: begin
            case ($urandom_range(0, 4))
               0: return POS_INF;
               1: return NEG_INF;
               2: return {1'b0, 11'h7FF, 20'($urandom), $urandom};
               3: return {$urandom_range(0, 1) == 1, 63'd0};
               default: return {$urandom_range(0, 1) == 1, 11'd0, 20'($urandom), $urandom};
            endcase
         end
         default: return {$urandom_range(0, 1) == 1, 11'(1003 + $urandom_range(0, 70)),
                          20'($urandom), $urandom};
      endcase
   endfunction

   function automatic logic [63:0] random_scale();
      return {$urandom_range(0, 1) == 1, 11'(1013 + $urandom_range(0, 30)),
              20'($urandom), $urandom};
   endfunction

   task automatic test_special_coords();
      coord_type list[$];
      list = '{POS_INF, NEG_INF, 64'h7FF8_0000_0000_0000, 64'hFFF0_0000_0000_0001,
               64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
               64'h0000_0000_0000_0001, 64'h7FEF_FFFF_FFFF_FFFF, 64'hFFEF_FFFF_FFFF_FFFF,
               $realtobits(0.5), $realtobits(1.5), $realtobits(2.5), $realtobits(-2.5),
               $realtobits(-0.5), $realtobits(0.49999999999999994),
               $realtobits(9.2e18), $realtobits(9.199999999999999e18),
               $realtobits(-9.2e18), $realtobits(-9.199999999999999e18),
               $realtobits(9007199254740993.0), $realtobits(4503599627370497.0),
               $realtobits(-4503599627370497.0), 64'hFFFF_FFFF_FFFF_FFFF,
               $realtobits(123.456)};
      foreach (list[i]) send_coord(list[i]);
      drain_results();
   endtask

   task automatic test_scale_extremes();
      logic [63:0] scales[$];
      scales = '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000, POS_INF, NEG_INF,
                 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001, 64'h7FEF_FFFF_FFFF_FFFF,
                 $realtobits(1.0e6), $realtobits(-1000.0), $realtobits(1.0e-3)};
      foreach (scales[k]) begin
         csr_write(scales[k]);
         send_coord(64'h0000_0000_0000_0000);
         send_coord($realtobits(2.5));
         send_coord($realtobits(-7.25));
         send_coord(random_coord());
         send_coord(random_coord());
         drain_results();
      end
   endtask

   task automatic test_random_stream();
      for (int p = 0; p < 12; p++) begin
         csr_write((p == 0) ? ONE_BITS : random_scale());
         repeat (45) send_coord(random_coord());
         drain_results();
      end
   endtask

   // A long receiver hold-off lets the pipeline fill and stall its input.
   task automatic test_backpressure();
      csr_write($realtobits(1024.0));
      hold_request = 1'b1;
      repeat (60) send_coord(random_coord());
      drain_results();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_special_coords();
      test_scale_extremes();
      test_random_stream();
      test_backpressure();
      if (error_count == 0 && expected_lattice.size() == 0) begin
         $display("snap_to_integer_lattice_tb: done, clean");
      end else begin
         $display("snap_to_integer_lattice_tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/stl_pkg.sv
hw/rtl/stl_req_if.sv
hw/rtl/stl_rsp_if.sv
hw/rtl/stl_mant_mul.sv
hw/rtl/snap_to_integer_lattice.sv
tb/snap_to_integer_lattice_tb.sv
